// ===== rtl/spfw_pkg.sv =====
// Shared constants for the spin pair flip weight pipeline.
package spfw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POL_BITS = 30;
  localparam int GAIN_BITS = 16;
  localparam logic [29:0] GAIN_Q = 30'd724077344;
  localparam int NORM_TOP = 30;
  localparam int SQ_RAD_W = 62;
  localparam int DIV_DEN_W = 63;
  localparam int DIV_Q_BITS = 30;

  localparam logic [0:0] REG_POL_FIRST = 1'b0;
  localparam logic [0:0] REG_POL_SECOND = 1'b1;

endpackage

// ===== rtl/spfw_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module spfw_sqrt #(
  parameter int RAD_W = spfw_pkg::SQ_RAD_W
) (
  input  logic                 clk,
  input  logic                 ce,
  input  logic [RAD_W-1:0]     radicand,
  output logic [RAD_W/2-1:0]   root
);

  localparam int ITERS = RAD_W / 2;

  logic [RAD_W-1:0] x_q [ITERS];
  logic [RAD_W-1:0] r_q [ITERS];
  logic [RAD_W-1:0] x_src [ITERS];
  logic [RAD_W-1:0] r_src [ITERS];
  logic [RAD_W-1:0] x_d [ITERS];
  logic [RAD_W-1:0] r_d [ITERS];

  always_comb begin
    x_src[0] = radicand;
    r_src[0] = '0;
    for (int i = 1; i < ITERS; i++) begin
      x_src[i] = x_q[i-1];
      r_src[i] = r_q[i-1];
    end
    for (int i = 0; i < ITERS; i++) begin
      if (x_src[i] >= r_src[i] + (RAD_W'(1) << (RAD_W - 2 - 2 * i))) begin
        x_d[i] = x_src[i] - (r_src[i] + (RAD_W'(1) << (RAD_W - 2 - 2 * i)));
        r_d[i] = (r_src[i] >> 1) + (RAD_W'(1) << (RAD_W - 2 - 2 * i));
      end else begin
        x_d[i] = x_src[i];
        r_d[i] = r_src[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < ITERS; i++) begin
        x_q[i] <= x_d[i];
        r_q[i] <= r_d[i];
      end
    end
  end

  assign root = r_q[ITERS-1][RAD_W/2-1:0];

endmodule

// ===== rtl/spfw_div.sv =====
// Pipelined restoring divider giving a saturated fraction quotient.
module spfw_div #(
  parameter int DEN_W = spfw_pkg::DIV_DEN_W,
  parameter int Q_BITS = spfw_pkg::DIV_Q_BITS
) (
  input  logic               clk,
  input  logic               ce,
  input  logic [DEN_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic [Q_BITS:0]    quo
);

  localparam int STAGES = Q_BITS + 1;

  logic [DEN_W-1:0]  r_q [STAGES];
  logic [Q_BITS-1:0] q_q [STAGES];
  logic [DEN_W-1:0]  den_q [STAGES];
  logic              sat_q [STAGES];
  logic [DEN_W:0]    r_shift [STAGES];
  logic [DEN_W:0]    r_sub [STAGES];

  always_comb begin
    r_shift[0] = '0;
    r_sub[0] = '0;
    for (int i = 1; i < STAGES; i++) begin
      r_shift[i] = {r_q[i-1], 1'b0};
      r_sub[i] = r_shift[i] - {1'b0, den_q[i-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sat_q[0] <= (num >= den);
      r_q[0] <= (num >= den) ? '0 : num;
      q_q[0] <= '0;
      den_q[0] <= den;
      for (int i = 1; i < STAGES; i++) begin
        sat_q[i] <= sat_q[i-1];
        den_q[i] <= den_q[i-1];
        if (r_shift[i] >= {1'b0, den_q[i-1]}) begin
          r_q[i] <= r_sub[i][DEN_W-1:0];
          q_q[i] <= {q_q[i-1][Q_BITS-2:0], 1'b1};
        end else begin
          r_q[i] <= r_shift[i][DEN_W-1:0];
          q_q[i] <= {q_q[i-1][Q_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = sat_q[STAGES-1] ? ((Q_BITS+1)'(1) << Q_BITS) : {1'b0, q_q[STAGES-1]};

endmodule

// ===== rtl/spin_pair_flip_weight.sv =====
// Top level of the spin pair flip weight pipeline.
//
//   Channel  Direction  Payload
//   s_*      in         tdata: hyperfine_a, hyperfine_b, pair_coupling
//   m_*      out        tdata: abs_difference, flip_weight, coupling_out
//   cfg_*    in         polarization_first (0), polarization_second (1)
//
// One transaction is taken every cycle while the output is not stalled.
// The latency is set by the 31-stage square root and the 31-stage divider.
// Reset clears every valid bit; the polarization registers reset to zero.
// A stall on the output freezes the whole pipeline, so nothing is lost.
module spin_pair_flip_weight (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // hyperfine_a, hyperfine_b, pair_coupling
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // abs_difference, flip_weight, coupling_out
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int SQ_LAT = spfw_pkg::SQ_RAD_W / 2;
  localparam int DIV_LAT = spfw_pkg::DIV_Q_BITS + 1;

  typedef struct packed {
    logic        v;
    logic [31:0] dm;
    logic [31:0] c;
    logic [6:0]  sh;
    logic [59:0] cs2;
    logic [59:0] kk;
    logic        kdiff;
  } sq_side_t;

  typedef struct packed {
    logic        v;
    logic [31:0] dm;
    logic [31:0] c;
    logic [6:0]  sh;
    logic [63:0] e2;
  } div_side_t;

  logic        ce;
  logic [31:0] pol0;
  logic [31:0] pol1;
  logic [31:0] p0m;
  logic [31:0] p1m;

  logic signed [32:0] d_full;
  logic [32:0] d_mag;
  logic [32:0] c_mag;

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;
  logic [31:0] dm1, dm2, dm3, dm4, dm5, dm6, dm7, dm8, dm9, dm10, dm11, dm12, dm13;
  logic [31:0] c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12, c13;
  logic [31:0] cm1, cm2, cm3, cm4;
  logic dneg1;
  logic [63:0] prod0_2, prod1_2;
  logic kn0_2, kn1_2, kn0_3, kn1_3, kn0_4, kn1_4, kn0_5, kn1_5, kdiff6, kdiff7;
  logic [33:0] k0m3, k1m3, m3, k0m4, k1m4;
  logic [33:0] k0m_c, k1m_c, m_c;
  logic [5:0]  msb_c;
  logic signed [6:0] z4;
  logic [29:0] cs5, k0s5, k1s5;
  logic [6:0]  sh5, sh6, sh7, sh8, sh9, sh10, sh11, sh12, sh13;
  logic [59:0] cs2_6, k0q6, k1q6, kk6;
  logic [59:0] cs2_7, kk7;
  logic [61:0] x0_7, x1_7;
  logic [30:0] e0, e1;
  sq_side_t    sq_in;
  sq_side_t    sq_d [SQ_LAT];
  logic [61:0] pe8;
  logic [59:0] cs2_8, kk8;
  logic        kdiff8;
  logic [31:0] e8;
  logic signed [64:0] num_c;
  logic [62:0] num9, den9;
  logic [63:0] e2_9;
  logic [30:0] s30;
  div_side_t   div_in;
  div_side_t   div_d [DIV_LAT];
  logic [62:0] pl10, ph10;
  logic [94:0] asum_c;
  logic [63:0] a11;
  logic [61:0] gl12, gh12;
  logic [93:0] tot13;
  logic [93:0] shifted_c;

  logic [47:0] flip_q;
  logic [31:0] absd_q;
  logic [31:0] cout_q;

  function automatic logic [29:0] scale_mag(input logic [33:0] v, input logic signed [6:0] z);
    logic [33:0] t;
    logic [2:0]  rs;
    logic [33:0] lost;
    begin
      t = '0;
      rs = '0;
      lost = '0;
      if (!z[6]) begin
        t = v << z[5:0];
        return t[29:0];
      end else begin
        rs = 3'(-z);
        t = v >> rs;
        lost = v & ((34'(1) << rs) - 34'(1));
        return t[29:0] | {29'b0, (lost != '0)};
      end
    end
  endfunction

  assign ce = !m_tvalid || m_tready;
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      pol0 <= '0;
      pol1 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spfw_pkg::REG_POL_FIRST: pol0 <= cfg_data;
        spfw_pkg::REG_POL_SECOND: pol1 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign p0m = pol0[31] ? (32'd0 - pol0) : pol0;
  assign p1m = pol1[31] ? (32'd0 - pol1) : pol1;

  assign d_full = $signed({s_tdata[31], s_tdata[31:0]}) - $signed({s_tdata[63], s_tdata[63:32]});
  assign d_mag = d_full[32] ? (33'd0 - d_full) : d_full;
  assign c_mag = s_tdata[95] ? (33'd0 - {1'b1, s_tdata[95:64]}) : {1'b0, s_tdata[95:64]};

  always_comb begin
    k0m_c = prod0_2[63:spfw_pkg::POL_BITS];
    k1m_c = prod1_2[63:spfw_pkg::POL_BITS];
    m_c = {2'b0, cm2};
    if (k0m_c > m_c) begin
      m_c = k0m_c;
    end
    if (k1m_c > m_c) begin
      m_c = k1m_c;
    end
  end

  always_comb begin
    msb_c = '0;
    for (int i = 0; i < 34; i++) begin
      if (m3[i]) begin
        msb_c = 6'(i);
      end
    end
  end

  always_comb begin
    sq_in.v = v7;
    sq_in.dm = dm7;
    sq_in.c = c7;
    sq_in.sh = sh7;
    sq_in.cs2 = cs2_7;
    sq_in.kk = kk7;
    sq_in.kdiff = kdiff7;
  end

  spfw_sqrt #(.RAD_W(spfw_pkg::SQ_RAD_W)) u_sqrt0 (
    .clk(clk), .ce(ce), .radicand(x0_7), .root(e0)
  );

  spfw_sqrt #(.RAD_W(spfw_pkg::SQ_RAD_W)) u_sqrt1 (
    .clk(clk), .ce(ce), .radicand(x1_7), .root(e1)
  );

  always_comb begin
    if (kdiff8 && kk8 != '0) begin
      num_c = $signed({3'b0, pe8}) - $signed({5'b0, cs2_8}) + $signed({5'b0, kk8});
    end else begin
      num_c = $signed({3'b0, pe8}) - $signed({5'b0, cs2_8}) - $signed({5'b0, kk8});
    end
  end

  always_comb begin
    div_in.v = v9;
    div_in.dm = dm9;
    div_in.c = c9;
    div_in.sh = sh9;
    div_in.e2 = e2_9;
  end

  spfw_div #(.DEN_W(spfw_pkg::DIV_DEN_W), .Q_BITS(spfw_pkg::DIV_Q_BITS)) u_div (
    .clk(clk), .ce(ce), .num(num9), .den(den9), .quo(s30)
  );

  assign asum_c = {ph10, 32'b0} + {32'b0, pl10};
  assign shifted_c = tot13 >> sh13;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
      v11 <= 1'b0; v12 <= 1'b0; v13 <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < SQ_LAT; i++) begin
        sq_d[i].v <= 1'b0;
      end
      for (int i = 0; i < DIV_LAT; i++) begin
        div_d[i].v <= 1'b0;
      end
    end else if (ce) begin
      v1 <= s_tvalid && (d_full != '0) && (s_tdata[95:64] != '0);
      dm1 <= d_mag[31:0];
      cm1 <= c_mag[31:0];
      dneg1 <= d_full[32];
      c1 <= s_tdata[95:64];

      v2 <= v1;
      prod0_2 <= 64'(dm1) * 64'(p0m);
      prod1_2 <= 64'(dm1) * 64'(p1m);
      kn0_2 <= dneg1 != pol0[31];
      kn1_2 <= dneg1 != pol1[31];
      cm2 <= cm1; dm2 <= dm1; c2 <= c1;

      v3 <= v2;
      k0m3 <= k0m_c; k1m3 <= k1m_c; m3 <= m_c;
      kn0_3 <= kn0_2; kn1_3 <= kn1_2;
      cm3 <= cm2; dm3 <= dm2; c3 <= c2;

      v4 <= v3;
      z4 <= 7'(spfw_pkg::NORM_TOP - 1 - int'(msb_c));
      k0m4 <= k0m3; k1m4 <= k1m3; cm4 <= cm3;
      kn0_4 <= kn0_3; kn1_4 <= kn1_3;
      dm4 <= dm3; c4 <= c3;

      v5 <= v4;
      cs5 <= scale_mag({2'b0, cm4}, z4);
      k0s5 <= scale_mag(k0m4, z4);
      k1s5 <= scale_mag(k1m4, z4);
      sh5 <= 7'(spfw_pkg::GAIN_BITS + spfw_pkg::FRAC_BITS + 2 * int'(z4));
      kn0_5 <= kn0_4; kn1_5 <= kn1_4;
      dm5 <= dm4; c5 <= c4;

      v6 <= v5;
      cs2_6 <= 60'(cs5) * 60'(cs5);
      k0q6 <= 60'(k0s5) * 60'(k0s5);
      k1q6 <= 60'(k1s5) * 60'(k1s5);
      kk6 <= 60'(k0s5) * 60'(k1s5);
      kdiff6 <= kn0_5 != kn1_5;
      sh6 <= sh5; dm6 <= dm5; c6 <= c5;

      v7 <= v6;
      x0_7 <= 62'(cs2_6) + 62'(k0q6);
      x1_7 <= 62'(cs2_6) + 62'(k1q6);
      cs2_7 <= cs2_6; kk7 <= kk6; kdiff7 <= kdiff6;
      sh7 <= sh6; dm7 <= dm6; c7 <= c6;

      sq_d[0] <= sq_in;
      for (int i = 1; i < SQ_LAT; i++) begin
        sq_d[i] <= sq_d[i-1];
      end

      v8 <= sq_d[SQ_LAT-1].v;
      pe8 <= 62'(e0) * 62'(e1);
      e8 <= 32'(e0) + 32'(e1);
      cs2_8 <= sq_d[SQ_LAT-1].cs2;
      kk8 <= sq_d[SQ_LAT-1].kk;
      kdiff8 <= sq_d[SQ_LAT-1].kdiff;
      sh8 <= sq_d[SQ_LAT-1].sh;
      dm8 <= sq_d[SQ_LAT-1].dm;
      c8 <= sq_d[SQ_LAT-1].c;

      v9 <= v8 && !num_c[64];
      num9 <= num_c[62:0];
      den9 <= {pe8, 1'b0};
      e2_9 <= 64'(e8) * 64'(e8);
      sh9 <= sh8; dm9 <= dm8; c9 <= c8;

      div_d[0] <= div_in;
      for (int i = 1; i < DIV_LAT; i++) begin
        div_d[i] <= div_d[i-1];
      end

      v10 <= div_d[DIV_LAT-1].v;
      pl10 <= 63'(div_d[DIV_LAT-1].e2[31:0]) * 63'(s30);
      ph10 <= 63'(div_d[DIV_LAT-1].e2[63:32]) * 63'(s30);
      sh10 <= div_d[DIV_LAT-1].sh;
      dm10 <= div_d[DIV_LAT-1].dm;
      c10 <= div_d[DIV_LAT-1].c;

      v11 <= v10;
      a11 <= asum_c[93:30];
      sh11 <= sh10; dm11 <= dm10; c11 <= c10;

      v12 <= v11;
      gl12 <= 62'(a11[31:0]) * 62'(spfw_pkg::GAIN_Q);
      gh12 <= 62'(a11[63:32]) * 62'(spfw_pkg::GAIN_Q);
      sh12 <= sh11; dm12 <= dm11; c12 <= c11;

      v13 <= v12;
      tot13 <= {gh12, 32'b0} + {32'b0, gl12};
      sh13 <= sh12; dm13 <= dm12; c13 <= c12;

      m_tvalid <= v13;
      flip_q <= (shifted_c[93:48] != '0) ? 48'hFFFF_FFFF_FFFF : shifted_c[47:0];
      absd_q <= dm13;
      cout_q <= c13;
    end
  end

  assign m_tdata = {cout_q, flip_q, absd_q};

endmodule
